// ===== hdl/cob_pkg.sv =====
`default_nettype none

package cob_pkg;

    localparam int SHAPE_WORDS = 4096;
    localparam int SHAPE_AW    = $clog2(SHAPE_WORDS);
    localparam int MAX_SIDE    = 64;
    localparam int SIDE_BITS   = $clog2(MAX_SIDE);
    localparam int COORD_BITS  = 13;
    localparam int STAGES      = 6;

    localparam logic [7:0] ALPHA_FULL = 8'hFF;
    localparam int         ROUND_HALF = 255 / 2;

    typedef enum logic [1:0] {
        MODE_ALPHA  = 2'd0,
        MODE_MONO   = 2'd1,
        MODE_MASKED = 2'd2,
        MODE_OFF    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_CURSOR_LEFT    = 3'd0,
        REG_CURSOR_TOP     = 3'd1,
        REG_SHAPE_WIDTH    = 3'd2,
        REG_SHAPE_HEIGHT   = 3'd3,
        REG_MASK_ROW_BYTES = 3'd4,
        REG_BLEND_MODE     = 3'd5
    } reg_index_t;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_BLEND = 1'b1
    } op_t;

endpackage

`default_nettype wire

// ===== hdl/cursor_overlay_blend.sv =====
// Hardware cursor overlay.
// s_axis carries one request per cycle while s_axis_tready is high: tuser selects
// a shape store load or a frame pixel to blend. Loads write one 32-bit shape word
// and give no result; each blend gives exactly one pixel on m_axis, in request order.
// Pixels inside the cursor window are changed according to blend_mode
// (alpha, monochrome AND/XOR mask, masked colour); all others pass unchanged.
// cfg writes the six window/mode registers; write them only while no pixel
// is in flight.
// Throughput: one request per clock while m_axis_tready is high, through the
// six-stage pipeline, with the shape store read (two read ports, one write
// port) registered alongside stage 3.
// A load followed at once by a blend that reads the same word sees the new word.
// Reset empties the pipeline and restores the registers to left 0, top 0,
// 32x32 shape, 4 mask bytes per row, mode off. The shape store is not cleared.
// When m_axis_tready is low, stages fill up behind the output register;
// s_axis_tready falls only when all six stages hold a request.
`default_nettype none

module cursor_overlay_blend (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [2:0]   cfg_index,
    input  wire logic [13:0]  cfg_data,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [11:0] shape_address, [43:12] shape_word, [56:44] pixel_col,
    // [69:57] pixel_row, [101:70] pixel_in, [103:102] zero
    input  wire logic [103:0] s_axis_tdata,
    // [0] operation
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [31:0] pixel_out
    output logic [31:0]       m_axis_tdata
);

    localparam int AW = cob_pkg::SHAPE_AW;
    localparam int SB = cob_pkg::SIDE_BITS;
    localparam int CB = cob_pkg::COORD_BITS;
    localparam int NS = cob_pkg::STAGES;

    // configuration
    logic signed [CB:0] cursor_left_reg, cursor_top_reg;
    logic [6:0]         shape_width_reg, shape_height_reg;
    logic [3:0]         mask_row_bytes_reg;
    cob_pkg::mode_t     blend_mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_left_reg    <= '0;
            cursor_top_reg     <= '0;
            shape_width_reg    <= 7'd32;
            shape_height_reg   <= 7'd32;
            mask_row_bytes_reg <= 4'd4;
            blend_mode_reg     <= cob_pkg::MODE_OFF;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cob_pkg::reg_index_t'(cfg_index))
                cob_pkg::REG_CURSOR_LEFT:    cursor_left_reg    <= cfg_data[CB:0];
                cob_pkg::REG_CURSOR_TOP:     cursor_top_reg     <= cfg_data[CB:0];
                cob_pkg::REG_SHAPE_WIDTH:    shape_width_reg    <= cfg_data[6:0];
                cob_pkg::REG_SHAPE_HEIGHT:   shape_height_reg   <= cfg_data[6:0];
                cob_pkg::REG_MASK_ROW_BYTES: mask_row_bytes_reg <= cfg_data[3:0];
                cob_pkg::REG_BLEND_MODE:     blend_mode_reg     <= cob_pkg::mode_t'(cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    logic [6:0] width_sat, height_sat;
    assign width_sat  = (shape_width_reg > 7'(cob_pkg::MAX_SIDE)) ?
                        7'(cob_pkg::MAX_SIDE) : shape_width_reg;
    assign height_sat = (shape_height_reg > 7'(cob_pkg::MAX_SIDE)) ?
                        7'(cob_pkg::MAX_SIDE) : shape_height_reg;

    // pipeline flow control
    logic [NS-1:0] v_reg, v_next;
    logic [NS:0]   ready;
    logic [NS-1:0] load;
    logic          mem_we, mem_re;

    always_comb
    begin
        ready[NS] = m_axis_tready;
        for (int k = NS - 1; k >= 0; k--)
            ready[k] = !v_reg[k] || ready[k+1];
    end

    cob_pkg::op_t s0_op_reg, s1_op_reg, s2_op_reg;

    always_comb
    begin
        v_next = v_reg;
        for (int k = 0; k < NS; k++)
        begin
            if (ready[k])
            begin
                if (k == 0)
                    v_next[k] = s_axis_tvalid;
                else if (k == 3)
                    v_next[k] = v_reg[2] && (s2_op_reg == cob_pkg::OP_BLEND);
                else
                    v_next[k] = v_reg[k-1];
            end
        end
        load = ready[NS-1:0] & v_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
            v_reg <= v_next;
    end

    assign s_axis_tready = ready[0];
    assign mem_we = v_reg[2] && ready[3] && (s2_op_reg == cob_pkg::OP_LOAD);
    assign mem_re = load[3];

    // stage 0: input register
    logic [11:0]   s0_addr_reg;
    logic [31:0]   s0_word_reg, s0_pix_reg;
    logic [CB-1:0] s0_col_reg, s0_row_reg;

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            s0_op_reg   <= cob_pkg::op_t'(s_axis_tuser);
            s0_addr_reg <= s_axis_tdata[11:0];
            s0_word_reg <= s_axis_tdata[43:12];
            s0_col_reg  <= s_axis_tdata[44 +: CB];
            s0_row_reg  <= s_axis_tdata[57 +: CB];
            s0_pix_reg  <= s_axis_tdata[101:70];
        end
    end

    // stage 1: window offsets
    logic signed [CB+1:0] diff_x, diff_y;
    logic                 s1_inwin_next;
    logic [11:0]          s1_addr_reg;
    logic [31:0]          s1_word_reg, s1_pix_reg;
    logic [SB-1:0]        s1_dx_reg, s1_dy_reg;
    logic                 s1_inwin_reg;

    always_comb
    begin
        diff_x = $signed({2'b00, s0_col_reg}) - $signed({cursor_left_reg[CB], cursor_left_reg});
        diff_y = $signed({2'b00, s0_row_reg}) - $signed({cursor_top_reg[CB], cursor_top_reg});
        s1_inwin_next = (blend_mode_reg != cob_pkg::MODE_OFF)
                     && !diff_x[CB+1] && (diff_x[CB:0] < (CB+1)'(width_sat))
                     && !diff_y[CB+1] && (diff_y[CB:0] < (CB+1)'(height_sat));
    end

    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            s1_op_reg    <= s0_op_reg;
            s1_addr_reg  <= s0_addr_reg;
            s1_word_reg  <= s0_word_reg;
            s1_pix_reg   <= s0_pix_reg;
            s1_dx_reg    <= diff_x[SB-1:0];
            s1_dy_reg    <= diff_y[SB-1:0];
            s1_inwin_reg <= s1_inwin_next;
        end
    end

    // stage 2: shape store addresses
    logic [13:0]   color_idx;
    logic [10:0]   and_byte, xor_byte;
    logic [7:0]    dy_xor;
    logic          s2_mono_ok_next;
    logic [11:0]   s2_addr_reg;
    logic [31:0]   s2_word_reg, s2_pix_reg;
    logic [AW-1:0] s2_color_reg, s2_and_reg, s2_xor_reg;
    logic [1:0]    s2_and_lane_reg, s2_xor_lane_reg;
    logic [2:0]    s2_bit_reg;
    logic          s2_inwin_reg, s2_mono_ok_reg;

    always_comb
    begin
        color_idx = 14'(s1_dy_reg) * 14'(width_sat) + 14'(s1_dx_reg);
        dy_xor    = 8'(s1_dy_reg) + 8'(height_sat);
        and_byte  = 11'(s1_dy_reg) * 11'(mask_row_bytes_reg) + 11'(s1_dx_reg[SB-1:3]);
        xor_byte  = 11'(dy_xor) * 11'(mask_row_bytes_reg) + 11'(s1_dx_reg[SB-1:3]);
        s2_mono_ok_next = 4'(s1_dx_reg[SB-1:3]) < mask_row_bytes_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            s2_op_reg       <= s1_op_reg;
            s2_addr_reg     <= s1_addr_reg;
            s2_word_reg     <= s1_word_reg;
            s2_pix_reg      <= s1_pix_reg;
            s2_inwin_reg    <= s1_inwin_reg;
            s2_color_reg    <= color_idx[AW-1:0];
            s2_and_reg      <= AW'(and_byte[10:2]);
            s2_xor_reg      <= AW'(xor_byte[10:2]);
            s2_and_lane_reg <= and_byte[1:0];
            s2_xor_lane_reg <= xor_byte[1:0];
            s2_bit_reg      <= s1_dx_reg[2:0];
            s2_mono_ok_reg  <= s2_mono_ok_next;
        end
    end

    // shape store: loads write and blends read in request order
    logic [31:0]   shape_mem [cob_pkg::SHAPE_WORDS];
    logic [AW-1:0] rd_addr_a;
    logic [31:0]   rd_a_reg, rd_b_reg;

    assign rd_addr_a = (blend_mode_reg == cob_pkg::MODE_MONO) ? s2_and_reg : s2_color_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            shape_mem[s2_addr_reg[AW-1:0]] <= s2_word_reg;
        if (mem_re)
        begin
            rd_a_reg <= shape_mem[rd_addr_a];
            rd_b_reg <= shape_mem[s2_xor_reg];
        end
    end

    // stage 3: blend-side context alongside the store data
    logic [31:0] s3_pix_reg;
    logic [1:0]  s3_and_lane_reg, s3_xor_lane_reg;
    logic [2:0]  s3_bit_reg;
    logic        s3_inwin_reg, s3_mono_ok_reg;

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            s3_pix_reg      <= s2_pix_reg;
            s3_and_lane_reg <= s2_and_lane_reg;
            s3_xor_lane_reg <= s2_xor_lane_reg;
            s3_bit_reg      <= s2_bit_reg;
            s3_inwin_reg    <= s2_inwin_reg;
            s3_mono_ok_reg  <= s2_mono_ok_reg;
        end
    end

    // stage 4: mask and replace modes resolved, alpha products formed
    logic [7:0]  cur_alpha, and_bits, xor_bits;
    logic [31:0] s4_pix_next;
    logic        s4_blend_next;
    logic [15:0] prod_next [3];
    logic [31:0] s4_pix_reg;
    logic        s4_blend_reg;
    logic [15:0] s4_prod_reg [3];
    logic [23:0] s4_color_reg;

    always_comb
    begin
        cur_alpha     = rd_a_reg[31:24];
        and_bits      = rd_a_reg[{s3_and_lane_reg, 3'b000} +: 8];
        xor_bits      = rd_b_reg[{s3_xor_lane_reg, 3'b000} +: 8];
        s4_pix_next   = s3_pix_reg;
        s4_blend_next = 1'b0;
        if (s3_inwin_reg)
        begin
            case (blend_mode_reg)
                cob_pkg::MODE_ALPHA:
                begin
                    if (cur_alpha == cob_pkg::ALPHA_FULL)
                        s4_pix_next = rd_a_reg;
                    else
                        s4_blend_next = 1'b1;
                end
                cob_pkg::MODE_MONO:
                begin
                    if (s3_mono_ok_reg)
                    begin
                        if (!and_bits[~s3_bit_reg])
                            s4_pix_next = '0;
                        if (xor_bits[~s3_bit_reg])
                            s4_pix_next = ~s4_pix_next;
                    end
                end
                cob_pkg::MODE_MASKED:
                begin
                    if (cur_alpha == cob_pkg::ALPHA_FULL)
                        s4_pix_next = s3_pix_reg ^ rd_a_reg;
                    else
                        s4_pix_next = rd_a_reg;
                end
                default: ;
            endcase
        end
        for (int k = 0; k < 3; k++)
            prod_next[k] = 16'(s3_pix_reg[8*k +: 8]) * 16'(cob_pkg::ALPHA_FULL - cur_alpha);
    end

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            s4_pix_reg   <= s4_pix_next;
            s4_blend_reg <= s4_blend_next;
            s4_color_reg <= rd_a_reg[23:0];
            for (int k = 0; k < 3; k++)
                s4_prod_reg[k] <= prod_next[k];
        end
    end

    // stage 5: divide by 255 with rounding, add cursor colour, saturate
    logic [16:0] rounded [3];
    logic [16:0] quot [3];
    logic [8:0]  chan_sum [3];
    logic [31:0] s5_pix_next, s5_pix_reg;

    always_comb
    begin
        s5_pix_next = s4_pix_reg;
        if (s4_blend_reg)
        begin
            s5_pix_next[31:24] = s4_pix_reg[31:24];
        end
        for (int k = 0; k < 3; k++)
        begin
            rounded[k]  = 17'(s4_prod_reg[k]) + 17'(cob_pkg::ROUND_HALF);
            quot[k]     = (rounded[k] + (rounded[k] >> 8) + 17'd1) >> 8;
            chan_sum[k] = 9'(s4_color_reg[8*k +: 8]) + quot[k][8:0];
            if (s4_blend_reg)
                s5_pix_next[8*k +: 8] = chan_sum[k][8] ? 8'hFF : chan_sum[k][7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[5])
            s5_pix_reg <= s5_pix_next;
    end

    assign m_axis_tvalid = v_reg[5];
    assign m_axis_tdata  = s5_pix_reg;

    // a full stall means every stage holds a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> ((&v_reg) && !m_axis_tready))
        else $error("input stalled with a free pipeline stage");

    // a load leaves the pipeline at the store, a blend goes on to stage 3
    assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[2] && ready[3]) |=>
            (v_reg[3] == ($past(s2_op_reg) == cob_pkg::OP_BLEND)))
        else $error("stage 3 occupancy does not match the request kind");

    // a store write never shares a cycle with a store read
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |=> !v_reg[3] && !$past(mem_re))
        else $error("shape store write overlapped a read");

endmodule

`default_nettype wire
